>>> rtl/core/traffic_light_with_night_mode_macros.svh
// Assertion macros for the traffic light controller checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef TRAFFIC_LIGHT_WITH_NIGHT_MODE_MACROS_SVH
`define TRAFFIC_LIGHT_WITH_NIGHT_MODE_MACROS_SVH

// checked only outside reset
`define TLNM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TLNM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/tlnm_pkg.sv
// Types and constants for the traffic light controller with night mode.
// No dependencies; used by every module of the block by scoped names.
package tlnm_pkg;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int LIGHT_W     = 12;

  localparam logic [CFG_INDEX_W-1:0] CFG_DARK_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GREEN_TICKS    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_YELLOW_TICKS   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RED_TICKS      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CROSSING_TICKS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_TICKS    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_TICKS   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TICKS = 3'd7;

  localparam logic [LIGHT_W-1:0]    RST_DARK_THRESHOLD = 12'd2500;
  localparam logic [CFG_DATA_W-1:0] RST_GREEN_TICKS    = 16'd5000;
  localparam logic [CFG_DATA_W-1:0] RST_YELLOW_TICKS   = 16'd2000;
  localparam logic [CFG_DATA_W-1:0] RST_RED_TICKS      = 16'd5000;
  localparam logic [CFG_DATA_W-1:0] RST_CROSSING_TICKS = 16'd5000;
  localparam logic [CFG_DATA_W-1:0] RST_BLINK_TICKS    = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] RST_SAMPLE_TICKS   = 16'd500;
  localparam logic [CFG_DATA_W-1:0] RST_DEBOUNCE_TICKS = 16'd50;

  localparam logic [1:0] PHASE_GREEN  = 2'd0;
  localparam logic [1:0] PHASE_YELLOW = 2'd1;
  localparam logic [1:0] PHASE_RED    = 2'd2;
  localparam logic [1:0] PHASE_CROSS  = 2'd3;

  localparam logic [1:0] LAMP_OFF    = 2'd0;
  localparam logic [1:0] LAMP_GREEN  = 2'd1;
  localparam logic [1:0] LAMP_YELLOW = 2'd2;
  localparam logic [1:0] LAMP_RED    = 2'd3;

  typedef enum logic [3:0] {
    ST_GREEN  = 4'b0001,
    ST_YELLOW = 4'b0010,
    ST_RED    = 4'b0100,
    ST_CROSS  = 4'b1000
  } phase_st_t;

  typedef struct packed {
    logic               button_event;
    logic [LIGHT_W-1:0] light_sample;
  } in_word_t;

  typedef struct packed {
    logic [1:0] lamp;
    logic [1:0] phase;
    logic       night_active;
    logic       request_waiting;
  } out_word_t;

  typedef struct packed {
    logic [LIGHT_W-1:0]    dark_threshold;
    logic [CFG_DATA_W-1:0] green_ticks;
    logic [CFG_DATA_W-1:0] yellow_ticks;
    logic [CFG_DATA_W-1:0] red_ticks;
    logic [CFG_DATA_W-1:0] crossing_ticks;
    logic [CFG_DATA_W-1:0] blink_ticks;
    logic [CFG_DATA_W-1:0] sample_ticks;
    logic [CFG_DATA_W-1:0] debounce_ticks;
  } cfg_t;

endpackage

>>> rtl/core/tlnm_cfg.sv
// Configuration register bank of the traffic light controller.
// Depends on tlnm_pkg.
module tlnm_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tlnm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tlnm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output tlnm_pkg::cfg_t                    cfg
);

  tlnm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dark_threshold <= tlnm_pkg::RST_DARK_THRESHOLD;
      cfg_r.green_ticks    <= tlnm_pkg::RST_GREEN_TICKS;
      cfg_r.yellow_ticks   <= tlnm_pkg::RST_YELLOW_TICKS;
      cfg_r.red_ticks      <= tlnm_pkg::RST_RED_TICKS;
      cfg_r.crossing_ticks <= tlnm_pkg::RST_CROSSING_TICKS;
      cfg_r.blink_ticks    <= tlnm_pkg::RST_BLINK_TICKS;
      cfg_r.sample_ticks   <= tlnm_pkg::RST_SAMPLE_TICKS;
      cfg_r.debounce_ticks <= tlnm_pkg::RST_DEBOUNCE_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        tlnm_pkg::CFG_DARK_THRESHOLD:
          cfg_r.dark_threshold <= cfg_wdata[tlnm_pkg::LIGHT_W-1:0];
        tlnm_pkg::CFG_GREEN_TICKS:    cfg_r.green_ticks    <= cfg_wdata;
        tlnm_pkg::CFG_YELLOW_TICKS:   cfg_r.yellow_ticks   <= cfg_wdata;
        tlnm_pkg::CFG_RED_TICKS:      cfg_r.red_ticks      <= cfg_wdata;
        tlnm_pkg::CFG_CROSSING_TICKS: cfg_r.crossing_ticks <= cfg_wdata;
        tlnm_pkg::CFG_BLINK_TICKS:    cfg_r.blink_ticks    <= cfg_wdata;
        tlnm_pkg::CFG_SAMPLE_TICKS:   cfg_r.sample_ticks   <= cfg_wdata;
        tlnm_pkg::CFG_DEBOUNCE_TICKS: cfg_r.debounce_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/tlnm_core.sv
// Controller state and one-tick next-state logic: timers, light sampling,
// button debounce, phase sequencing and lamp decode. Depends on tlnm_pkg.
module tlnm_core #(
  parameter int TIMER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  tlnm_pkg::in_word_t  in_word,
  input  tlnm_pkg::cfg_t      cfg,
  output tlnm_pkg::out_word_t res_word
);

  localparam int CW = (TIMER_BITS > tlnm_pkg::CFG_DATA_W) ? TIMER_BITS : tlnm_pkg::CFG_DATA_W;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  tlnm_pkg::phase_st_t   phase_r, phase_nxt;
  logic                  night_r, night_nxt;
  logic                  blink_r, blink_nxt;
  logic                  req_r, req_nxt;
  logic [TIMER_BITS-1:0] phase_el_r, phase_el_nxt;
  logic [TIMER_BITS-1:0] blink_el_r, blink_el_nxt;
  logic [TIMER_BITS-1:0] sample_el_r, sample_el_nxt;
  logic [TIMER_BITS-1:0] press_el_r, press_el_nxt;

  logic dark;

  always_comb begin
    phase_nxt     = phase_r;
    night_nxt     = night_r;
    blink_nxt     = blink_r;
    req_nxt       = req_r;
    phase_el_nxt  = (phase_el_r  == TMAX) ? phase_el_r  : phase_el_r  + 1'b1;
    blink_el_nxt  = (blink_el_r  == TMAX) ? blink_el_r  : blink_el_r  + 1'b1;
    sample_el_nxt = (sample_el_r == TMAX) ? sample_el_r : sample_el_r + 1'b1;
    press_el_nxt  = (press_el_r  == TMAX) ? press_el_r  : press_el_r  + 1'b1;
    dark          = in_word.light_sample > cfg.dark_threshold;

    // light sensor
    if (CW'(sample_el_nxt) >= CW'(cfg.sample_ticks)) begin
      sample_el_nxt = '0;
      if (dark != night_nxt && phase_nxt != tlnm_pkg::ST_CROSS) begin
        if (dark) begin
          blink_nxt    = 1'b1;
          blink_el_nxt = '0;
        end else begin
          phase_nxt    = tlnm_pkg::ST_GREEN;
          phase_el_nxt = '0;
        end
      end
      night_nxt = dark;
    end

    // debounced button
    if (in_word.button_event && CW'(press_el_nxt) >= CW'(cfg.debounce_ticks)) begin
      press_el_nxt = '0;
      if (phase_nxt != tlnm_pkg::ST_CROSS) begin
        req_nxt = 1'b1;
      end
    end

    if (phase_nxt == tlnm_pkg::ST_CROSS) begin
      if (CW'(phase_el_nxt) >= CW'(cfg.crossing_ticks)) begin
        phase_nxt = tlnm_pkg::ST_GREEN;
        if (night_nxt) begin
          blink_nxt    = 1'b1;
          blink_el_nxt = '0;
        end else begin
          phase_el_nxt = '0;
        end
      end
    end else if (night_nxt) begin
      if (req_nxt) begin
        req_nxt      = 1'b0;
        phase_nxt    = tlnm_pkg::ST_CROSS;
        phase_el_nxt = '0;
      end else if (CW'(blink_el_nxt) >= CW'(cfg.blink_ticks)) begin
        blink_el_nxt = '0;
        blink_nxt    = !blink_nxt;
      end
    end else begin
      case (phase_nxt)
        tlnm_pkg::ST_GREEN: begin
          if (req_nxt || CW'(phase_el_nxt) >= CW'(cfg.green_ticks)) begin
            phase_nxt    = tlnm_pkg::ST_YELLOW;
            phase_el_nxt = '0;
          end
        end
        tlnm_pkg::ST_YELLOW: begin
          if (CW'(phase_el_nxt) >= CW'(cfg.yellow_ticks)) begin
            phase_nxt    = req_nxt ? tlnm_pkg::ST_CROSS : tlnm_pkg::ST_RED;
            req_nxt      = 1'b0;
            phase_el_nxt = '0;
          end
        end
        tlnm_pkg::ST_RED: begin
          if (req_nxt) begin
            req_nxt      = 1'b0;
            phase_nxt    = tlnm_pkg::ST_CROSS;
            phase_el_nxt = '0;
          end else if (CW'(phase_el_nxt) >= CW'(cfg.red_ticks)) begin
            phase_nxt    = tlnm_pkg::ST_GREEN;
            phase_el_nxt = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // result word from the state after this tick
  always_comb begin
    res_word.night_active    = night_nxt;
    res_word.request_waiting = req_nxt;
    case (phase_nxt)
      tlnm_pkg::ST_GREEN:  res_word.phase = tlnm_pkg::PHASE_GREEN;
      tlnm_pkg::ST_YELLOW: res_word.phase = tlnm_pkg::PHASE_YELLOW;
      tlnm_pkg::ST_RED:    res_word.phase = tlnm_pkg::PHASE_RED;
      default:             res_word.phase = tlnm_pkg::PHASE_CROSS;
    endcase
    if (phase_nxt == tlnm_pkg::ST_CROSS) begin
      res_word.lamp = tlnm_pkg::LAMP_RED;
    end else if (night_nxt) begin
      res_word.lamp = blink_nxt ? tlnm_pkg::LAMP_YELLOW : tlnm_pkg::LAMP_OFF;
    end else begin
      case (phase_nxt)
        tlnm_pkg::ST_GREEN:  res_word.lamp = tlnm_pkg::LAMP_GREEN;
        tlnm_pkg::ST_YELLOW: res_word.lamp = tlnm_pkg::LAMP_YELLOW;
        default:             res_word.lamp = tlnm_pkg::LAMP_RED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tlnm_pkg::ST_GREEN;
      night_r     <= 1'b0;
      blink_r     <= 1'b0;
      req_r       <= 1'b0;
      phase_el_r  <= '0;
      blink_el_r  <= '0;
      sample_el_r <= '0;
      press_el_r  <= '0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      night_r     <= night_nxt;
      blink_r     <= blink_nxt;
      req_r       <= req_nxt;
      phase_el_r  <= phase_el_nxt;
      blink_el_r  <= blink_el_nxt;
      sample_el_r <= sample_el_nxt;
      press_el_r  <= press_el_nxt;
    end
  end

endmodule

>>> rtl/core/traffic_light_with_night_mode.sv
// Traffic light controller with pedestrian button and night blink mode.
// Each input word is one millisecond tick and yields exactly one result word
// holding the lamp, phase and mode after that tick. A word is registered on
// input, runs through the tick logic and lands in the output register, and a
// new word is taken every cycle while the output side keeps up; the output
// register sets that pace. Timers are TIMER_BITS wide and saturate. The user
// must write configuration through cfg_we, cfg_index and cfg_wdata only while
// the block is idle; the block itself does not enforce this. Depends on
// tlnm_pkg, tlnm_cfg and tlnm_core.
module traffic_light_with_night_mode #(
  parameter int TIMER_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tlnm_pkg::in_word_t                in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tlnm_pkg::out_word_t               out_word,
  input  logic                              cfg_we,
  input  logic [tlnm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tlnm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  tlnm_pkg::cfg_t      cfg;
  tlnm_pkg::in_word_t  in_word_r;
  tlnm_pkg::out_word_t res_word;
  tlnm_pkg::out_word_t out_word_r;
  logic                in_valid_r, in_valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                advance;
  logic                step_en;
  logic                in_take;

  assign advance  = !out_valid_r || !out_stall;
  assign step_en  = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_word;
    end
    if (step_en) begin
      out_word_r <= res_word;
    end
  end

  tlnm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tlnm_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .in_word  (in_word_r),
    .cfg      (cfg),
    .res_word (res_word)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> rtl/core/tlnm_checker.sv
// Port-level checks for the traffic light controller, bound to the top level.
// Depends on tlnm_pkg and traffic_light_with_night_mode_macros.svh.
`include "traffic_light_with_night_mode_macros.svh"

module tlnm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input tlnm_pkg::out_word_t out_word
);

  property p_out_hold;
    out_valid && out_stall |=> out_valid && $stable(out_word);
  endproperty

  property p_cross_red;
    out_valid && out_word.phase == tlnm_pkg::PHASE_CROSS |->
      out_word.lamp == tlnm_pkg::LAMP_RED;
  endproperty

  property p_night_blink;
    out_valid && out_word.night_active && out_word.phase != tlnm_pkg::PHASE_CROSS |->
      out_word.lamp == tlnm_pkg::LAMP_OFF || out_word.lamp == tlnm_pkg::LAMP_YELLOW;
  endproperty

  property p_day_green;
    out_valid && !out_word.night_active && out_word.phase == tlnm_pkg::PHASE_GREEN |->
      out_word.lamp == tlnm_pkg::LAMP_GREEN;
  endproperty

  `TLNM_ASSERT(a_out_hold, p_out_hold, "stalled word changed")
  `TLNM_ASSERT(a_cross_red, p_cross_red, "crossing without red lamp")
  `TLNM_ASSERT(a_night_blink, p_night_blink, "night lamp not blinking yellow")
  `TLNM_ASSERT(a_day_green, p_day_green, "green phase without green lamp")
  `TLNM_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid, "result word valid after reset")

endmodule

bind traffic_light_with_night_mode tlnm_checker u_tlnm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
